/* hw/rtl/slir_pkg.sv */
package slir_pkg;

    // Store depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Command word
    typedef struct packed {
        logic                    cmd;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    // Response word
    typedef struct packed {
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] smallest;
    } t_out_word;

    // Per-cycle update strobes broadcast along the row of cells
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

/* hw/rtl/slir_cell.sv */
// One slot of the sorted row. Compares its entry with the broadcast key and
// either keeps it, takes the key, or takes a neighbour's entry.
module slir_cell (
    input  logic                              i_clk,
    input  slir_pkg::t_cell_ctl               i_ctl,
    input  logic signed [slir_pkg::VAL_W-1:0] i_key,
    input  logic                              i_occ,
    input  logic signed [slir_pkg::VAL_W-1:0] i_left,
    input  logic                              i_left_pos_le,
    input  logic signed [slir_pkg::VAL_W-1:0] i_right,
    output logic signed [slir_pkg::VAL_W-1:0] o_entry,
    output logic signed [slir_pkg::VAL_W-1:0] o_next,
    output logic                              o_pos_le,
    output logic                              o_eq
);

    logic signed [slir_pkg::VAL_W-1:0] r_entry;
    logic signed [slir_pkg::VAL_W-1:0] n_entry;
    logic                              w_key_lt;
    logic                              w_entry_lt;

    // Local compares
    assign w_key_lt   = i_key < r_entry;
    assign w_entry_lt = r_entry < i_key;

    // Insert point is at or before this slot: empty, or entry larger than key
    assign o_pos_le = !i_occ || w_key_lt;
    assign o_eq     = i_occ && (r_entry == i_key);

    // Next entry: shift right from the insert point, shift left from the match
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_left_pos_le) begin
                n_entry = i_left;
            end else if (o_pos_le) begin
                n_entry = i_key;
            end
        end else if (i_ctl.rem) begin
            if (!i_occ || !w_entry_lt) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

/* hw/rtl/sorted_list_insert_remove_core.sv */
// Sorted list of up to CAPACITY signed 32-bit keys, kept in a row of cells.
// Input channel (i_in_valid / o_in_ready / i_in_word): one command word,
// cmd insert or remove plus the key. Output channel (o_out_valid /
// i_out_ready / o_out_word): one response word per command with status,
// entry count after the command and the smallest entry (zero when empty).
// The response is registered and appears in the cycle after the command is
// taken. Throughput: one command per cycle while the receiver keeps up; every
// cell compares its entry with the key in parallel and shifts in the same cycle.
// Inserts place the key after equal entries; removes drop one equal entry.
// An insert into a full list answers full and changes nothing; a remove
// with no match answers not found.
// Reset empties the list (count to zero) and drops any pending response.
// When the receiver stalls the response is held in the output register and
// o_in_ready falls, so no command is taken until the word is delivered.
module sorted_list_insert_remove_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slir_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slir_pkg::t_out_word o_out_word
);

    localparam int CAP   = slir_pkg::CAPACITY;
    localparam int CNT_W = slir_pkg::CNT_W;
    localparam int VAL_W = slir_pkg::VAL_W;

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    slir_pkg::t_out_word         r_out_word;
    logic [1:0]                  w_status;
    logic                        w_accept;
    logic                        w_full;
    logic                        w_found;
    slir_pkg::t_cell_ctl         w_ctl;
    logic [CAP-1:0]              w_occ;
    logic [CAP-1:0]              w_pos_le;
    logic [CAP-1:0]              w_eq;
    logic signed [VAL_W-1:0]     w_entry [CAP];
    logic signed [VAL_W-1:0]     w_next  [CAP];

    // Handshake: take a word whenever the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = r_count == CNT_W'(CAP);
    assign w_found = |w_eq;

    // Update strobes for the row
    assign w_ctl.ins = w_accept && (i_in_word.cmd == slir_pkg::CMD_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_in_word.cmd == slir_pkg::CMD_REMOVE) && w_found;

    // Row of cells
    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;
        logic                    w_left_pos_le;

        assign w_occ[gi] = CNT_W'(gi) < r_count;

        if (gi == 0) begin : g_first
            assign w_left        = '0;
            assign w_left_pos_le = 1'b0;
        end else begin : g_inner
            assign w_left        = w_entry[gi-1];
            assign w_left_pos_le = w_pos_le[gi-1];
        end

        if (gi == CAP - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_entry[gi+1];
        end

        slir_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_key         (i_in_word.value),
            .i_occ         (w_occ[gi]),
            .i_left        (w_left),
            .i_left_pos_le (w_left_pos_le),
            .i_right       (w_right),
            .o_entry       (w_entry[gi]),
            .o_next        (w_next[gi]),
            .o_pos_le      (w_pos_le[gi]),
            .o_eq          (w_eq[gi])
        );
    end

    // Status and next count
    always_comb begin
        n_count  = r_count;
        w_status = slir_pkg::ST_NOT_FOUND;
        if (i_in_word.cmd == slir_pkg::CMD_INSERT) begin
            if (w_full) begin
                w_status = slir_pkg::ST_FULL;
            end else begin
                w_status = slir_pkg::ST_INSERTED;
                n_count  = r_count + CNT_W'(1);
            end
        end else if (w_found) begin
            w_status = slir_pkg::ST_REMOVED;
            n_count  = r_count - CNT_W'(1);
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word.status   <= w_status;
            r_out_word.count    <= n_count;
            r_out_word.smallest <= (n_count == '0) ? '0 : w_next[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    logic [CAP-1:0] w_sort_ok;

    // Neighbouring occupied entries stay in ascending order
    for (genvar gs = 0; gs < CAP - 1; gs++) begin : g_sort_chk
        assign w_sort_ok[gs] = !w_occ[gs+1] || (w_entry[gs] <= w_entry[gs+1]);
    end
    assign w_sort_ok[CAP-1] = 1'b1;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAP))
        else $error("entry count above capacity");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_sort_ok)
        else $error("list out of order");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in_word.cmd == slir_pkg::CMD_REMOVE) && (r_count == '0)
        |=> o_out_word.status == slir_pkg::ST_NOT_FOUND)
        else $error("remove on empty list not flagged");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_full && (i_in_word.cmd == slir_pkg::CMD_INSERT)
        |=> (r_count == CNT_W'(CAP)) && (o_out_word.status == slir_pkg::ST_FULL))
        else $error("insert into full list changed state");

    a_resp_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid && (o_out_word.count == r_count))
        else $error("response missing or count mismatch");
`endif

endmodule
